// ===== rtl/slipchk_pkg.sv =====
package slipchk_pkg;

  // frame size limit and field widths
  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned CountW        = 12;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [CountW-1:0] MaxFrameCount = CountW'(MaxFrameBytes);
  localparam logic [CountW-1:0] MinIpv4Len    = CountW'(20);

  // ipv4 header fields in the first byte
  localparam logic [7:0] VersionMask = 8'hf0;
  localparam logic [7:0] Version4    = 8'h40;
  localparam logic [3:0] MinIhl      = 4'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEndCode      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEscapeCode   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEscEndCode   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEscEscCode   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEscNulCode   = 3'd4;

  // result kinds
  localparam logic KindData  = 1'b0;
  localparam logic KindFrame = 1'b1;

  // frame status codes
  localparam logic [StatusW-1:0] StatusOk       = 3'd0;
  localparam logic [StatusW-1:0] StatusShort    = 3'd1;
  localparam logic [StatusW-1:0] StatusVersion  = 3'd2;
  localparam logic [StatusW-1:0] StatusIhl      = 3'd3;
  localparam logic [StatusW-1:0] StatusChecksum = 3'd4;
  localparam logic [StatusW-1:0] StatusOverflow = 3'd5;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] escaped_end_code;
    logic [7:0] escaped_escape_code;
    logic [7:0] escaped_nul_code;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data_byte;
    logic [StatusW-1:0] frame_status;
    logic [CountW-1:0]  frame_length;
  } result_t;

endpackage

// ===== rtl/slip_deframer_ipv4_check_unit.sv =====
// channel   dir  handshake               payload
// input     in   in_valid_i/in_ready_o   raw_byte_i
// result    out  out_valid_o/out_ready_i kind_o, data_byte_o, frame_status_o, frame_length_o
// config    in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one raw byte per cycle while the result register is not stalled; a taken request
// is held in the input register and decoded, and its result is registered in the result register
// bytes that yield nothing (escape, zero, dropped) still pass the input register but load no result
// reset clears the frame state and loads the default SLIP codes
// a stalled result register holds back the input register and then in_ready_o
module slip_deframer_ipv4_check_unit
  import slipchk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         raw_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [7:0]         data_byte_o,
  output logic [StatusW-1:0] frame_status_o,
  output logic [CountW-1:0]  frame_length_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  cfg_t       cfg_q;
  logic       advance;
  logic       step;
  logic [7:0] byte_s;
  logic       res_valid;
  result_t    res_d;
  result_t    res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_code            <= 8'd192;
      cfg_q.escape_code         <= 8'd219;
      cfg_q.escaped_end_code    <= 8'd220;
      cfg_q.escaped_escape_code <= 8'd221;
      cfg_q.escaped_nul_code    <= 8'd222;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEndCode:    cfg_q.end_code            <= cfg_wdata_i;
        CfgEscapeCode: cfg_q.escape_code         <= cfg_wdata_i;
        CfgEscEndCode: cfg_q.escaped_end_code    <= cfg_wdata_i;
        CfgEscEscCode: cfg_q.escaped_escape_code <= cfg_wdata_i;
        CfgEscNulCode: cfg_q.escaped_nul_code    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  slipchk_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .raw_byte_i (raw_byte_i),
    .advance_i  (advance),
    .step_o     (step),
    .byte_o     (byte_s)
  );

  // decoder and frame checker
  slipchk_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .byte_i      (byte_s),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  // result register
  slipchk_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_d),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign kind_o         = res_q.kind;
  assign data_byte_o    = res_q.data_byte;
  assign frame_status_o = res_q.frame_status;
  assign frame_length_o = res_q.frame_length;

endmodule

// ===== rtl/slipchk_in_reg.sv =====
module slipchk_in_reg
  import slipchk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] raw_byte_i,
  input  logic       advance_i,
  output logic       step_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // stage may take a new request when empty or when its item moves on
  assign in_ready_o = !valid_q || advance_i;
  assign step_o     = valid_q && advance_i;
  assign byte_o     = byte_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // byte holding register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= raw_byte_i;
    end
  end

endmodule

// ===== rtl/slipchk_decode.sv =====
module slipchk_decode
  import slipchk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic              escaping_q,  escaping_d;
  logic [CountW-1:0] count_q,     count_d;
  logic [7:0]        first_q,     first_d;
  logic [15:0]       sum_q,       sum_d;
  logic [7:0]        pending_q,   pending_d;

  logic              full;
  logic              keep;
  logic              close;
  logic [7:0]        dbyte;
  logic [7:0]        lead;
  logic [CountW-1:0] hdr_len;
  logic [CountW-1:0] hdr_len_st;
  logic [16:0]       sum_raw;
  logic [15:0]       sum_fold;
  logic [StatusW-1:0] status;

  assign full = (count_q >= MaxFrameCount);

  // frame status from the stored header state
  assign hdr_len_st = CountW'({first_q[3:0], 2'b00});
  always_comb begin
    if (full) begin
      status = StatusOverflow;
    end else if (count_q < MinIpv4Len) begin
      status = StatusShort;
    end else if ((first_q & VersionMask) != Version4) begin
      status = StatusVersion;
    end else if (first_q[3:0] < MinIhl) begin
      status = StatusIhl;
    end else if (count_q < hdr_len_st) begin
      status = StatusShort;
    end else if (sum_q != 16'hffff) begin
      status = StatusChecksum;
    end else begin
      status = StatusOk;
    end
  end

  // byte classification and unescaping
  always_comb begin
    close      = 1'b0;
    keep       = 1'b0;
    dbyte      = byte_i;
    escaping_d = escaping_q;
    if (full) begin
      close = (byte_i == cfg_i.end_code);
    end else if (byte_i == cfg_i.end_code && byte_i != cfg_i.escape_code) begin
      close = 1'b1;
    end else if (byte_i == cfg_i.escape_code) begin
      escaping_d = 1'b1;
    end else if (byte_i == cfg_i.escaped_end_code) begin
      keep = 1'b1;
      if (escaping_q) begin
        dbyte      = cfg_i.end_code;
        escaping_d = 1'b0;
      end
    end else if (byte_i == cfg_i.escaped_escape_code) begin
      keep = 1'b1;
      if (escaping_q) begin
        dbyte      = cfg_i.escape_code;
        escaping_d = 1'b0;
      end
    end else if (byte_i == cfg_i.escaped_nul_code) begin
      keep = 1'b1;
      if (escaping_q) begin
        dbyte      = 8'h00;
        escaping_d = 1'b0;
      end
    end else if (byte_i != 8'h00 && !escaping_q) begin
      keep = 1'b1;
    end
  end

  // header checksum and counters for a kept byte
  assign lead     = (count_q == '0) ? dbyte : first_q;
  assign hdr_len  = CountW'({lead[3:0], 2'b00});
  assign sum_raw  = {1'b0, sum_q} + {1'b0, pending_q, dbyte};
  assign sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};

  always_comb begin
    count_d   = count_q;
    first_d   = first_q;
    sum_d     = sum_q;
    pending_d = pending_q;
    if (close) begin
      count_d   = '0;
      first_d   = '0;
      sum_d     = '0;
      pending_d = '0;
    end else if (keep) begin
      count_d = count_q + CountW'(1);
      if (count_q == '0) begin
        first_d = dbyte;
      end
      if (count_q < hdr_len) begin
        if (!count_q[0]) begin
          pending_d = dbyte;
        end else begin
          sum_d = sum_fold;
        end
      end
    end
  end

  // result toward the output register
  assign res_valid_o = step_i && (close || keep);
  always_comb begin
    res_o.kind         = close ? KindFrame : KindData;
    res_o.data_byte    = close ? 8'h00 : dbyte;
    res_o.frame_status = close ? status : StatusOk;
    res_o.frame_length = close ? count_q : '0;
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escaping_q <= 1'b0;
      count_q    <= '0;
      first_q    <= '0;
      sum_q      <= '0;
      pending_q  <= '0;
    end else if (step_i) begin
      escaping_q <= close ? 1'b0 : escaping_d;
      count_q    <= count_d;
      first_q    <= first_d;
      sum_q      <= sum_d;
      pending_q  <= pending_d;
    end
  end

endmodule

// ===== rtl/slipchk_out_reg.sv =====
module slipchk_out_reg
  import slipchk_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // register is free when empty or being drained this cycle
  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule
